@@ hdl/spbi_pkg.sv @@
`default_nettype none
package spbi_pkg;

  localparam int SPBI_MAX_VERTICES = 64;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MB_W    = DIFF_W + 1;
  localparam int PROD_W  = DIFF_W + MB_W;
  localparam int CRS_W   = PROD_W;
  localparam int LO_W    = DIFF_W;
  localparam int ACC_W   = 80;
  localparam int IDX_W   = 6;
  localparam int FC_W    = 7;
  localparam int EPS_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_EPSILON = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] SEL_PV = 2'd0;
  localparam logic [1:0] SEL_QV = 2'd1;
  localparam logic [1:0] SEL_D  = 2'd0;
  localparam logic [1:0] SEL_U  = 2'd1;
  localparam logic [1:0] SEL_V  = 2'd2;
  localparam logic [1:0] SEL_T  = 2'd3;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [CRS_W-1:0]   crs_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef coord_t [2:0]              pt_t;

  typedef struct packed {
    logic       wr;
    logic       start;
    logic       latch_i;
    logic       latch_nx;
    logic       setup;
    logic       tri_sel;
    logic       mv;
    logic       dot;
    logic [1:0] sel;
    logic [1:0] comp;
    logic       term;
    logic       first;
    logic       last;
    logic       norm;
  } dp_cmd_t;

endpackage
`default_nettype wire

@@ hdl/segment_prism_boundary_intersect.sv @@
`default_nettype none
// load: result registered in S_DONE after the input transfer, next input taken in S_IDLE
// query: vertices read and latched in S_RD_I, S_RD_NX, S_WAIT; per triangle S_SETUP,
//   36 products through one 25x26 multiplier, S_DRAIN, S_NORM and S_CHECK, stopping at
//   the first crossed triangle; result registered in S_DONE, next input taken in S_IDLE
// the next input is taken while a result waits on the output
// reset (synchronous, rst_n low): face_count 3, det_epsilon 1, no result pending;
//   vertex store is not cleared
module segment_prism_boundary_intersect
  import spbi_pkg::*;
#(
  parameter int MAX_VERTICES = SPBI_MAX_VERTICES,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // vertex_index, a_x, a_y, a_z, b_x, b_y, b_z, zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // hit, zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // is_query
  output logic                       out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [EPS_W-1:0]      cfg_wdata
);

  logic [FC_W-1:0]  face_count_r;
  logic [EPS_W-1:0] det_epsilon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_count_r  <= FC_W'(3);
      det_epsilon_r <= EPS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FACE_COUNT:  face_count_r  <= cfg_wdata[FC_W-1:0];
        CFG_DET_EPSILON: det_epsilon_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dp_cmd_t         cmd;
  logic [AW-1:0]   rd_addr;
  logic            tri_hit;
  logic            hit;
  pt_t             in_a, in_b;

  for (genvar k = 0; k < 3; k++) begin : g_pt
    assign in_a[k] = in_tdata[IDX_W + k*COORD_W +: COORD_W];
    assign in_b[k] = in_tdata[IDX_W + (k+3)*COORD_W +: COORD_W];
  end

  spbi_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_cmd       (in_tuser),
    .in_ready     (in_tready),
    .face_count   (face_count_r),
    .tri_hit      (tri_hit),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .out_valid    (out_tvalid),
    .out_is_query (out_tuser),
    .out_hit      (hit),
    .out_ready    (out_tready)
  );

  spbi_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .in_vertex_index (in_tdata[IDX_W-1:0]),
    .in_a            (in_a),
    .in_b            (in_b),
    .det_epsilon     (det_epsilon_r),
    .tri_hit         (tri_hit)
  );

  assign out_tdata = {{(OUT_DATA_W-1){1'b0}}, hit};

endmodule
`default_nettype wire

@@ hdl/spbi_dpath.sv @@
`default_nettype none
module spbi_dpath
  import spbi_pkg::*;
#(
  parameter int MAX_VERTICES = SPBI_MAX_VERTICES,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_cmd_t          cmd,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic [IDX_W-1:0] in_vertex_index,
  input  wire pt_t              in_a,
  input  wire pt_t              in_b,
  input  wire logic [EPS_W-1:0] det_epsilon,
  output logic                  tri_hit
);

  localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [6*COORD_W-1:0] mem_r [MAX_VERTICES];
  logic [6*COORD_W-1:0] rdata_r;
  logic [IW-1:0]        idx_ext;
  logic                 idx_ok;

  assign idx_ext = IW'(in_vertex_index);
  assign idx_ok  = idx_ext < IW'(MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (cmd.wr && idx_ok) begin
      mem_r[idx_ext[AW-1:0]] <= {in_b, in_a};
    end
    rdata_r <= mem_r[rd_addr];
  end

  pt_t near_i_r, far_i_r, near_nx_r, far_nx_r, orig_r;
  diff_t dir_r [3];
  diff_t e1_r [3];
  diff_t e2_r [3];
  diff_t tv_r [3];
  pt_t v1, v2, v3;

  assign v1 = near_i_r;
  assign v2 = cmd.tri_sel ? far_nx_r : far_i_r;
  assign v3 = cmd.tri_sel ? near_nx_r : far_nx_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      orig_r <= in_a;
      for (int k = 0; k < 3; k++) begin
        dir_r[k] <= {in_b[k][COORD_W-1], in_b[k]} - {in_a[k][COORD_W-1], in_a[k]};
      end
    end
    if (cmd.latch_i) begin
      near_i_r <= rdata_r[3*COORD_W-1:0];
      far_i_r  <= rdata_r[6*COORD_W-1:3*COORD_W];
    end
    if (cmd.latch_nx) begin
      near_nx_r <= rdata_r[3*COORD_W-1:0];
      far_nx_r  <= rdata_r[6*COORD_W-1:3*COORD_W];
    end
    if (cmd.setup) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= {v2[k][COORD_W-1], v2[k]} - {v1[k][COORD_W-1], v1[k]};
        e2_r[k] <= {v3[k][COORD_W-1], v3[k]} - {v1[k][COORD_W-1], v1[k]};
        tv_r[k] <= {orig_r[k][COORD_W-1], orig_r[k]} - {v1[k][COORD_W-1], v1[k]};
      end
    end
  end

  crs_t pv_r [3];
  crs_t qv_r [3];
  logic [1:0] i1, i2, ia, ib;
  diff_t mul_a;
  logic signed [MB_W-1:0] mul_b;
  diff_t bs;
  crs_t bv;
  logic mul_neg, mul_shift;

  always_comb begin
    case (cmd.comp)
      COMP_X: begin
        i1 = COMP_Y;
        i2 = COMP_Z;
      end
      COMP_Y: begin
        i1 = COMP_Z;
        i2 = COMP_X;
      end
      default: begin
        i1 = COMP_X;
        i2 = COMP_Y;
      end
    endcase
    ia = cmd.term ? i2 : i1;
    ib = cmd.term ? i1 : i2;
    mul_a     = dir_r[ia];
    bs        = e2_r[ib];
    bv        = pv_r[cmd.comp];
    mul_b     = {bs[DIFF_W-1], bs};
    mul_neg   = 1'b0;
    mul_shift = 1'b0;
    if (!cmd.dot) begin
      mul_neg = cmd.term;
      if (cmd.sel == SEL_QV) begin
        mul_a = tv_r[ia];
        bs    = e1_r[ib];
      end else begin
        mul_a = dir_r[ia];
        bs    = e2_r[ib];
      end
      mul_b = {bs[DIFF_W-1], bs};
    end else begin
      case (cmd.sel)
        SEL_D: begin
          mul_a = e1_r[cmd.comp];
          bv    = pv_r[cmd.comp];
        end
        SEL_U: begin
          mul_a = tv_r[cmd.comp];
          bv    = pv_r[cmd.comp];
        end
        SEL_V: begin
          mul_a = dir_r[cmd.comp];
          bv    = qv_r[cmd.comp];
        end
        default: begin
          mul_a = e2_r[cmd.comp];
          bv    = qv_r[cmd.comp];
        end
      endcase
      if (!cmd.term) begin
        mul_b     = bv[CRS_W-1:LO_W];
        mul_shift = 1'b1;
      end else begin
        mul_b = {1'b0, bv[LO_W-1:0]};
      end
    end
  end

  logic signed [PROD_W-1:0] prod_r;
  logic pm_v_r, pm_neg_r, pm_shift_r, pm_first_r, pm_last_r, pm_dot_r;
  logic [1:0] pm_sel_r, pm_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else begin
      pm_v_r <= cmd.mv;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_b;
    pm_neg_r   <= mul_neg;
    pm_shift_r <= mul_shift;
    pm_first_r <= cmd.first;
    pm_last_r  <= cmd.last;
    pm_dot_r   <= cmd.dot;
    pm_sel_r   <= cmd.sel;
    pm_comp_r  <= cmd.comp;
  end

  acc_t acc_r, acc_nxt, sp, term_v;
  acc_t d_r, u_r, v_r, t_r;

  always_comb begin
    if (pm_shift_r) begin
      sp = {{(ACC_W-PROD_W-LO_W){prod_r[PROD_W-1]}}, prod_r, {LO_W{1'b0}}};
    end else begin
      sp = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
    term_v  = pm_neg_r ? -sp : sp;
    acc_nxt = (pm_first_r ? '0 : acc_r) + term_v;
  end

  always_ff @(posedge clk) begin
    if (pm_v_r) begin
      acc_r <= acc_nxt;
      if (pm_last_r) begin
        if (!pm_dot_r) begin
          if (pm_sel_r == SEL_QV) begin
            qv_r[pm_comp_r] <= acc_nxt[CRS_W-1:0];
          end else begin
            pv_r[pm_comp_r] <= acc_nxt[CRS_W-1:0];
          end
        end else begin
          case (pm_sel_r)
            SEL_D:   d_r <= acc_nxt;
            SEL_U:   u_r <= acc_nxt;
            SEL_V:   v_r <= acc_nxt;
            default: t_r <= acc_nxt;
          endcase
        end
      end
    end
  end

  acc_t dn_r, un_r, vn_r, tn_r, eps_ext;
  logic nz_r;
  logic signed [ACC_W:0] uv;

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      nz_r <= d_r != '0;
      dn_r <= d_r[ACC_W-1] ? -d_r : d_r;
      un_r <= d_r[ACC_W-1] ? -u_r : u_r;
      vn_r <= d_r[ACC_W-1] ? -v_r : v_r;
      tn_r <= d_r[ACC_W-1] ? -t_r : t_r;
    end
  end

  assign eps_ext = acc_t'(det_epsilon);
  assign uv = $signed({un_r[ACC_W-1], un_r}) + $signed({vn_r[ACC_W-1], vn_r});

  assign tri_hit = nz_r && !(dn_r < eps_ext)
                && !un_r[ACC_W-1] && !(dn_r < un_r)
                && !vn_r[ACC_W-1] && !($signed({dn_r[ACC_W-1], dn_r}) < uv)
                && !tn_r[ACC_W-1] && !(dn_r < tn_r);

endmodule
`default_nettype wire

@@ hdl/spbi_ctrl.sv @@
`default_nettype none
module spbi_ctrl
  import spbi_pkg::*;
#(
  parameter int MAX_VERTICES = SPBI_MAX_VERTICES,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CW = ($clog2(MAX_VERTICES + 1) > FC_W) ? $clog2(MAX_VERTICES + 1) : FC_W
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  output logic                 in_ready,
  input  wire logic [FC_W-1:0] face_count,
  input  wire logic            tri_hit,
  output dp_cmd_t              cmd,
  output logic [AW-1:0]        rd_addr,
  output logic                 out_valid,
  output logic                 out_is_query,
  output logic                 out_hit,
  input  wire logic            out_ready
);

  localparam logic [1:0] COMP_LAST      = COMP_Z;
  localparam logic [1:0] SEL_LAST_CROSS = SEL_QV;
  localparam logic [1:0] SEL_LAST_DOT   = SEL_T;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD_I  = 10'b0000000010,
    S_RD_NX = 10'b0000000100,
    S_WAIT  = 10'b0000001000,
    S_SETUP = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_DRAIN = 10'b0001000000,
    S_NORM  = 10'b0010000000,
    S_CHECK = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] face_r, face_nxt, nface_r, nface_nxt, face_inc, nx, fc_ext;
  logic tri_r, tri_nxt, dot_r, dot_nxt, term_r, term_nxt;
  logic [1:0] sel_r, sel_nxt, comp_r, comp_nxt;
  logic res_q_r, res_q_nxt, res_hit_r, res_hit_nxt;
  logic out_valid_r, out_valid_nxt, out_q_r, out_q_nxt, out_hit_r, out_hit_nxt;
  logic in_fire;

  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign face_inc = face_r + CW'(1);
  assign nx       = (face_inc == nface_r) ? '0 : face_inc;
  assign fc_ext   = CW'(face_count);
  assign rd_addr  = (state_r == S_RD_NX) ? nx[AW-1:0] : face_r[AW-1:0];

  assign out_valid    = out_valid_r;
  assign out_is_query = out_q_r;
  assign out_hit      = out_hit_r;

  always_comb begin
    state_nxt     = state_r;
    face_nxt      = face_r;
    nface_nxt     = nface_r;
    tri_nxt       = tri_r;
    dot_nxt       = dot_r;
    term_nxt      = term_r;
    sel_nxt       = sel_r;
    comp_nxt      = comp_r;
    res_q_nxt     = res_q_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_q_nxt     = out_q_r;
    out_hit_nxt   = out_hit_r;
    cmd           = '0;
    cmd.tri_sel   = tri_r;
    cmd.dot       = dot_r;
    cmd.sel       = sel_r;
    cmd.comp      = comp_r;
    cmd.term      = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.wr      = 1'b1;
            res_q_nxt   = 1'b0;
            res_hit_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else begin
            cmd.start   = 1'b1;
            res_q_nxt   = 1'b1;
            res_hit_nxt = 1'b0;
            nface_nxt   = (fc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : fc_ext;
            face_nxt    = '0;
            tri_nxt     = 1'b0;
            state_nxt   = (fc_ext == '0) ? S_DONE : S_RD_I;
          end
        end
      end
      S_RD_I: begin
        state_nxt = S_RD_NX;
      end
      S_RD_NX: begin
        cmd.latch_i = 1'b1;
        state_nxt   = S_WAIT;
      end
      S_WAIT: begin
        cmd.latch_nx = 1'b1;
        state_nxt    = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        dot_nxt   = 1'b0;
        sel_nxt   = '0;
        comp_nxt  = '0;
        term_nxt  = 1'b0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mv    = 1'b1;
        cmd.first = !term_r && (!dot_r || comp_r == COMP_X);
        cmd.last  = term_r && (!dot_r || comp_r == COMP_LAST);
        if (!term_r) begin
          term_nxt = 1'b1;
        end else begin
          term_nxt = 1'b0;
          if (comp_r == COMP_LAST) begin
            comp_nxt = COMP_X;
            if (sel_r == (dot_r ? SEL_LAST_DOT : SEL_LAST_CROSS)) begin
              sel_nxt = '0;
              if (dot_r) begin
                dot_nxt   = 1'b0;
                state_nxt = S_DRAIN;
              end else begin
                dot_nxt = 1'b1;
              end
            end else begin
              sel_nxt = sel_r + 2'd1;
            end
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (tri_hit) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (!tri_r) begin
          tri_nxt   = 1'b1;
          state_nxt = S_SETUP;
        end else if (face_inc == nface_r) begin
          state_nxt = S_DONE;
        end else begin
          face_nxt  = face_inc;
          tri_nxt   = 1'b0;
          state_nxt = S_RD_I;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = res_q_r;
          out_hit_nxt   = res_hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      face_r      <= '0;
      nface_r     <= '0;
      tri_r       <= 1'b0;
      dot_r       <= 1'b0;
      term_r      <= 1'b0;
      sel_r       <= '0;
      comp_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      face_r      <= face_nxt;
      nface_r     <= nface_nxt;
      tri_r       <= tri_nxt;
      dot_r       <= dot_nxt;
      term_r      <= term_nxt;
      sel_r       <= sel_nxt;
      comp_r      <= comp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_q_r   <= res_q_nxt;
    res_hit_r <= res_hit_nxt;
    out_q_r   <= out_q_nxt;
    out_hit_r <= out_hit_nxt;
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spbi_pkg::*;

  localparam int N_ITEMS     = 650;
  localparam int STALL_LIMIT = 60000;

  typedef logic signed [127:0] wide_t;
  typedef struct { wide_t x, y, z; } wvec_t;
  typedef struct { logic is_query; logic hit; } answer_t;
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cidx;
    logic [EPS_W-1:0]     cval;
    logic                 cmd;
    logic [IDX_W-1:0]     vidx;
    int                   p[6];
    bit                   typed;
    logic                 thit;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [EPS_W-1:0]      cfg_wdata = '0;

  segment_prism_boundary_intersect u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  wvec_t            near_pt[SPBI_MAX_VERTICES];
  wvec_t            far_pt[SPBI_MAX_VERTICES];
  logic [FC_W-1:0]  face_cnt_q = 7'd3;
  logic [EPS_W-1:0] eps_q = 32'd1;
  answer_t          answers_q[$];
  bit               failed = 1'b0;
  int               items_sent = 0;
  int               snd_pct = 32;
  int               rcv_pct = 86;
  int               stall_cnt = 0;
  logic             typed_en = 1'b0;
  logic             typed_hit = 1'b0;

  function automatic wvec_t vsub(wvec_t a, wvec_t b);
    wvec_t r;
    r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wvec_t vcross(wvec_t a, wvec_t b);
    wvec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(wvec_t a, wvec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic bit tri_crossed(wvec_t o, wvec_t dir, wvec_t p1, wvec_t p2, wvec_t p3);
    wvec_t e1, e2, tv, pv, qv;
    wide_t d, mag, u, v, t, eps_w;
    e1 = vsub(p2, p1);
    e2 = vsub(p3, p1);
    tv = vsub(o, p1);
    pv = vcross(dir, e2);
    d = vdot(e1, pv);
    mag = (d < 0) ? -d : d;
    eps_w = {96'd0, eps_q};
    if (d == 0 || mag < eps_w) return 1'b0;
    qv = vcross(tv, e1);
    u = vdot(tv, pv);
    v = vdot(dir, qv);
    t = vdot(e2, qv);
    if (d < 0) begin
      d = -d; u = -u; v = -v; t = -t;
    end
    if (u < 0 || d < u) return 1'b0;
    if (v < 0 || d < u + v) return 1'b0;
    if (t < 0 || d < t) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit segment_crosses(wvec_t a, wvec_t b);
    int    n;
    int    nx;
    wvec_t dir;
    n = (face_cnt_q > SPBI_MAX_VERTICES) ? SPBI_MAX_VERTICES : int'(face_cnt_q);
    dir = vsub(b, a);
    for (int i = 0; i < n; i++) begin
      nx = (i + 1 == n) ? 0 : i + 1;
      if (tri_crossed(a, dir, near_pt[i], far_pt[i], far_pt[nx]) ||
          tri_crossed(a, dir, near_pt[i], far_pt[nx], near_pt[nx])) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic wvec_t field_pt(logic [IN_DATA_W-1:0] d, int base);
    wvec_t p;
    p.x = coord_t'(d[base +: COORD_W]);
    p.y = coord_t'(d[base + COORD_W +: COORD_W]);
    p.z = coord_t'(d[base + 2 * COORD_W +: COORD_W]);
    return p;
  endfunction

  // prediction at input transfer, check at output transfer
  always @(negedge clk) begin
    answer_t exp_a;
    wvec_t   pa, pb;
    int      vi;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pa = field_pt(in_tdata, IDX_W);
        pb = field_pt(in_tdata, IDX_W + 3 * COORD_W);
        if (in_tuser == CMD_LOAD) begin
          vi = int'(in_tdata[IDX_W-1:0]);
          if (vi < SPBI_MAX_VERTICES) begin
            near_pt[vi] = pa;
            far_pt[vi] = pb;
          end
          exp_a.is_query = 1'b0;
          exp_a.hit = 1'b0;
        end else begin
          exp_a.is_query = 1'b1;
          exp_a.hit = segment_crosses(pa, pb);
        end
        if (typed_en) exp_a.hit = typed_hit;
        answers_q.push_back(exp_a);
      end
      if (out_tvalid && out_tready) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result is_query=%0b hit=%0b", $time, out_tuser,
                   out_tdata[0]);
          failed = 1'b1;
        end else begin
          exp_a = answers_q.pop_front();
          if (out_tuser !== exp_a.is_query) begin
            $display("%0t: is_query expected %0b actual %0b", $time, exp_a.is_query,
                     out_tuser);
            failed = 1'b1;
          end
          if (out_tdata[0] !== exp_a.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_a.hit, out_tdata[0]);
            failed = 1'b1;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt > STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // called and returns at a rising edge
  task automatic send(input logic cmd, input logic [IDX_W-1:0] vidx, input int ax,
                      input int ay, input int az, input int bx, input int by, input int bz,
                      input bit typed, input logic thit);
    if (items_sent < N_ITEMS / 3) begin
      snd_pct = 32; rcv_pct = 86;
    end else if (items_sent < 2 * N_ITEMS / 3) begin
      snd_pct = 86; rcv_pct = 32;
    end else begin
      snd_pct = 0; rcv_pct = 0;
    end
    if ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, bz[23:0], by[23:0], bx[23:0], az[23:0], ay[23:0], ax[23:0], vidx};
    typed_en = typed;
    typed_hit = thit;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [EPS_W-1:0] val);
    in_tvalid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_FACE_COUNT) face_cnt_q = val[FC_W-1:0];
    else eps_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic row_t mk(bit is_cfg, logic [CFG_IDX_W-1:0] cidx, logic [EPS_W-1:0] cval,
                              logic cmd, logic [IDX_W-1:0] vidx, int ax, int ay, int az,
                              int bx, int by, int bz, bit typed, logic thit);
    row_t r;
    r.is_cfg = is_cfg; r.cidx = cidx; r.cval = cval;
    r.cmd = cmd; r.vidx = vidx;
    r.p[0] = ax; r.p[1] = ay; r.p[2] = az; r.p[3] = bx; r.p[4] = by; r.p[5] = bz;
    r.typed = typed; r.thit = thit;
    return r;
  endfunction

  function automatic int rnd_sym(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  initial begin
    row_t             plan[$];
    row_t             r;
    int               n_cfg, n_used, nq, kind;
    int               rad, zh, lim;
    int               ia[3], ib[3];
    logic [EPS_W-1:0] eps_v;
    real              ang;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // triangle prism around the z axis
    plan.push_back(mk(0, 0, 0, CMD_LOAD, 0, 8192, 0, -8192, 8192, 0, 8192, 1, 0));
    plan.push_back(mk(0, 0, 0, CMD_LOAD, 1, -4096, 7094, -8192, -4096, 7094, 8192, 1, 0));
    plan.push_back(mk(0, 0, 0, CMD_LOAD, 2, -4096, -7094, -8192, -4096, -7094, 8192, 1, 0));
    plan.push_back(mk(0, 0, 0, CMD_LOAD, 63, 8388607, 8388607, 8388607,
                      -8388608, -8388608, -8388608, 1, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 1000, 1000, 100, 0, 0));
    // zero-length segment, determinant is zero
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 63, 100, 200, 300, 100, 200, 300, 1, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 8388607, 8388607, 8388607,
                      -8388608, -8388608, -8388608, 0, 0));
    // segment ends on the face, ends on an edge, starts on the face
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 2048, 3547, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 8192, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 2048, 3547, 0, 6000, 6000, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, -8192, 16384, 0, -8192, 0, 0));
    plan.push_back(mk(1, CFG_FACE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 16384, 0, 0, 1, 0));
    plan.push_back(mk(1, CFG_FACE_COUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
    plan.push_back(mk(1, CFG_FACE_COUNT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, -16384, 100, 50, 0, 0));
    plan.push_back(mk(1, CFG_FACE_COUNT, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(1, CFG_DET_EPSILON, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
    plan.push_back(mk(1, CFG_DET_EPSILON, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, -16384, -300, 20, 0, 0));
    plan.push_back(mk(0, 0, 0, CMD_QUERY, 0, 0, 0, 0, 2048, 3547, 0, 0, 0));

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg) write_cfg(r.cidx, r.cval);
      else send(r.cmd, r.vidx, r.p[0], r.p[1], r.p[2], r.p[3], r.p[4], r.p[5],
                r.typed, r.thit);
    end

    while (items_sent < N_ITEMS) begin
      kind = $urandom_range(19);
      if (kind <= 12) n_cfg = 3 + $urandom_range(5);
      else if (kind == 13) n_cfg = 64;
      else if (kind == 14) n_cfg = 127;
      else if (kind == 15) n_cfg = 0;
      else if (kind == 16) n_cfg = 1;
      else if (kind == 17) n_cfg = 2;
      else n_cfg = 9 + $urandom_range(20);
      kind = $urandom_range(7);
      if (kind == 0) eps_v = 0;
      else if (kind == 1) eps_v = 1;
      else if (kind == 2) eps_v = 32'hFFFF_FFFF;
      else if (kind == 3) eps_v = $urandom;
      else eps_v = $urandom_range(4096);
      write_cfg(CFG_FACE_COUNT, n_cfg);
      write_cfg(CFG_DET_EPSILON, eps_v);
      n_used = (n_cfg > 64) ? 64 : n_cfg;
      rad = $urandom_range(256, 1 << 20);
      zh = $urandom_range(256, 1 << 21);
      for (int i = 0; i < n_used; i++) begin
        if ($urandom_range(15) == 0) begin
          send(CMD_LOAD, IDX_W'(i), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, 0, 0);
        end else begin
          ang = 6.283185307 * (real'(i) + 0.3 * real'($urandom_range(100)) / 100.0) /
                real'(n_used);
          ia[0] = $rtoi(rad * $cos(ang));
          ia[1] = $rtoi(rad * $sin(ang));
          send(CMD_LOAD, IDX_W'(i), ia[0], ia[1], -zh + rnd_sym(zh / 8),
               ia[0] + rnd_sym(rad / 16), ia[1] + rnd_sym(rad / 16), zh, 0, 0);
        end
      end
      if ($urandom_range(3) == 0)
        send(CMD_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, 0, 0);
      nq = $urandom_range(8, 20);
      lim = rad / 3;
      for (int q = 0; q < nq; q++) begin
        kind = $urandom_range(11);
        for (int k = 0; k < 2; k++) begin
          ia[k] = rnd_sym(lim);
          ib[k] = rnd_sym(lim);
        end
        ia[2] = rnd_sym(zh / 2);
        ib[2] = rnd_sym(zh / 2);
        if (kind <= 5) begin
          ang = 6.283185307 * real'($urandom_range(999)) / 1000.0;
          ib[0] = $rtoi(2.0 * rad * $cos(ang));
          ib[1] = $rtoi(2.0 * rad * $sin(ang));
          if (kind[0]) begin
            ia = ib;
            ib[0] = rnd_sym(lim); ib[1] = rnd_sym(lim); ib[2] = rnd_sym(zh / 2);
          end
        end else if (kind == 9) begin
          ib = ia;
        end else if (kind == 10) begin
          ia[0] = $urandom; ia[1] = $urandom; ia[2] = $urandom;
          ib[0] = $urandom; ib[1] = $urandom; ib[2] = $urandom;
        end else if (kind == 11) begin
          ia[2] = zh + 1 + $urandom_range(zh);
          ib[2] = ia[2] + $urandom_range(zh);
        end
        send(CMD_QUERY, IDX_W'($urandom), ia[0], ia[1], ia[2], ib[0], ib[1], ib[2], 0, 0);
      end
    end

    in_tvalid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
